>>> src/atr_pkg.sv
// Shared types and constants for the average true range block.
// Used by atr_front, atr_fifo, atr_back, atr_div and average_true_range.
package atr_pkg;

	localparam int PRICE_W     = 32;
	localparam int MAX_WINDOW  = 256;
	localparam int RING_AW     = $clog2(MAX_WINDOW);
	localparam int WIN_W       = 9;
	localparam int SEEN_W      = 9;
	localparam int TOTAL_W     = 40;
	localparam int FRAC_BITS   = 8;
	localparam int AVG_W       = 40;
	localparam int DIVIDEND_W  = TOTAL_W + FRAC_BITS;
	localparam int DIV_STEP_W  = 8;
	localparam int DIV_STAGES  = DIVIDEND_W / DIV_STEP_W;

	localparam logic [SEEN_W-1:0] SEEN_LIMIT   = SEEN_W'((1 << SEEN_W) - 1);
	localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(14);

	// queue depth must be a power of two
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW = REG_IDX_W'(0);

	// classified bar update, front to back
	typedef struct packed {
		logic [PRICE_W-1:0] tr;
		logic [RING_AW-1:0] pos;
		logic               sub;
		logic               avg_valid;
	} atr_entry_t;

	// updated window sum, back to divider
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [PRICE_W-1:0] tr;
		logic               avg_valid;
	} atr_sum_t;

endpackage

>>> src/atr_front.sv
// Front end: accepts bar updates, tracks bar count, ring slot and closes,
// and computes the true range. Depends on atr_pkg.
module atr_front import atr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	input  logic [WIN_W-1:0]   window,
	input  logic               bar_valid,
	output logic               bar_stall,
	input  logic [PRICE_W-1:0] bar_high,
	input  logic [PRICE_W-1:0] bar_low,
	input  logic [PRICE_W-1:0] bar_close,
	input  logic               new_bar,
	input  logic               full,
	output logic               push,
	output atr_entry_t         entry
);

	logic [SEEN_W-1:0]  bars_q;
	logic [RING_AW-1:0] pos_q;
	logic [PRICE_W-1:0] prior_q;
	logic [PRICE_W-1:0] cur_q;

	logic               start;
	logic               first;
	logic [WIN_W-1:0]   pos_inc;
	logic [RING_AW-1:0] pos_nx;
	logic [SEEN_W-1:0]  seen_nx;
	logic [PRICE_W-1:0] ref_price;
	logic [PRICE_W-1:0] top;
	logic [PRICE_W-1:0] bot;

	assign bar_stall = full;
	assign push      = bar_valid && !full;

	always_comb begin
		start     = (bars_q == '0);
		pos_inc   = WIN_W'(pos_q) + WIN_W'(1);
		ref_price = new_bar ? cur_q : prior_q;
		top       = (bar_high >= ref_price) ? bar_high : ref_price;
		bot       = (bar_low <= ref_price) ? bar_low : ref_price;
		entry.sub = 1'b0;
		if (start) begin
			pos_nx    = '0;
			first     = 1'b1;
			seen_nx   = SEEN_W'(1);
		end else if (new_bar) begin
			pos_nx    = (pos_inc == window) ? '0 : pos_inc[RING_AW-1:0];
			first     = 1'b0;
			seen_nx   = (bars_q == SEEN_LIMIT) ? bars_q : bars_q + SEEN_W'(1);
			entry.sub = (bars_q >= window);
		end else begin
			// revision: replace this bar's slot
			pos_nx    = pos_q;
			first     = (bars_q == SEEN_W'(1));
			seen_nx   = bars_q;
			entry.sub = 1'b1;
		end
		if (first) begin
			entry.tr = (bar_high > bar_low) ? bar_high - bar_low : '0;
		end else begin
			entry.tr = top - bot;
		end
		entry.pos       = pos_nx;
		entry.avg_valid = (seen_nx >= window);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bars_q  <= '0;
			pos_q   <= '0;
			prior_q <= '0;
			cur_q   <= '0;
		end else if (clear) begin
			bars_q  <= '0;
			pos_q   <= '0;
			prior_q <= '0;
			cur_q   <= '0;
		end else if (push) begin
			bars_q <= seen_nx;
			pos_q  <= pos_nx;
			cur_q  <= bar_close;
			if (!start && new_bar) begin
				prior_q <= cur_q;
			end
		end
	end

endmodule

>>> src/atr_fifo.sv
// Short queue of classified bar updates between front and back.
// Depends on atr_pkg.
module atr_fifo import atr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  atr_entry_t wr_entry,
	input  logic       pop,
	output atr_entry_t head,
	output logic       full,
	output logic       empty
);

	atr_entry_t         slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + FIFO_AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + FIFO_CW'(1);
				2'b01:   cnt_q <= cnt_q - FIFO_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/atr_back.sv
// Back end: read-modify-write of the true range ring and the window sum.
// Depends on atr_pkg; feeds atr_div.
module atr_back import atr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  logic       empty,
	input  atr_entry_t head,
	output logic       pop,
	output logic       sum_valid,
	output atr_sum_t   sum,
	input  logic       sum_stall
);

	typedef enum logic {S_IDLE, S_UPD} state_t;

	state_t             state_q;
	logic               sum_valid_q;
	logic [TOTAL_W-1:0] total_q;
	atr_sum_t           sum_q;
	atr_entry_t         cur_q;
	logic [PRICE_W-1:0] rd_data_q;
	logic [PRICE_W-1:0] ring_mem [MAX_WINDOW];

	logic               out_free;
	logic               wr_en;
	logic [TOTAL_W-1:0] total_nx;

	assign out_free  = !sum_valid_q || !sum_stall;
	assign pop       = (state_q == S_IDLE) && !empty;
	assign wr_en     = (state_q == S_UPD) && out_free;
	assign sum_valid = sum_valid_q;
	assign sum       = sum_q;
	assign total_nx  = total_q - (cur_q.sub ? TOTAL_W'(rd_data_q) : '0) + TOTAL_W'(cur_q.tr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[cur_q.pos] <= cur_q.tr;
		end
		if (pop) begin
			rd_data_q <= ring_mem[head.pos];
			cur_q     <= head;
		end
		if (wr_en) begin
			sum_q <= '{total: total_nx, tr: cur_q.tr, avg_valid: cur_q.avg_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (wr_en) begin
				sum_valid_q <= 1'b1;
			end else if (sum_valid_q && !sum_stall) begin
				sum_valid_q <= 1'b0;
			end
			if (clear) begin
				total_q <= '0;
			end else if (wr_en) begin
				total_q <= total_nx;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					// hold until the divider takes the previous sum
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_pop_starts_update: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == S_UPD)
		else $error("ring read not followed by update");

	a_no_pop_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> !pop)
		else $error("queue popped during ring update");

	a_update_offers_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD && out_free |=> sum_valid_q)
		else $error("completed update did not offer a sum");

endmodule

>>> src/atr_div.sv
// Pipelined restoring divider: window sum times 256 over the window length,
// eight quotient bits per stage, with the result register. Depends on atr_pkg.
module atr_div import atr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [WIN_W-1:0]   divisor,
	input  logic               sum_valid,
	input  atr_sum_t           sum,
	output logic               sum_stall,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [PRICE_W-1:0] true_range,
	output logic               average_valid,
	output logic [AVG_W-1:0]   range_average
);

	typedef struct packed {
		logic [DIVIDEND_W-1:0] nq;
		logic [WIN_W-1:0]      rem;
		logic [PRICE_W-1:0]    tr;
		logic                  avg_valid;
	} div_stage_t;

	function automatic div_stage_t div_step(input div_stage_t s, input logic [WIN_W-1:0] d);
		div_stage_t r;
		logic [WIN_W:0] acc;
		r = s;
		for (int i = 0; i < DIV_STEP_W; i++) begin
			acc  = {r.rem, r.nq[DIVIDEND_W-1]};
			r.nq = {r.nq[DIVIDEND_W-2:0], 1'b0};
			if (acc >= {1'b0, d}) begin
				acc     = acc - {1'b0, d};
				r.nq[0] = 1'b1;
			end
			r.rem = acc[WIN_W-1:0];
		end
		return r;
	endfunction

	div_stage_t stage_s [DIV_STAGES];
	logic       vld_s   [DIV_STAGES];
	div_stage_t src     [DIV_STAGES];
	logic       src_v   [DIV_STAGES];
	div_stage_t nxt     [DIV_STAGES];
	logic       free    [DIV_STAGES];

	always_comb begin
		src[0]   = '{nq: {sum.total, {FRAC_BITS{1'b0}}}, rem: '0, tr: sum.tr,
			avg_valid: sum.avg_valid};
		src_v[0] = sum_valid;
		for (int k = 1; k < DIV_STAGES; k++) begin
			src[k]   = stage_s[k-1];
			src_v[k] = vld_s[k-1];
		end
		for (int k = 0; k < DIV_STAGES; k++) begin
			nxt[k] = div_step(src[k], divisor);
		end
		free[DIV_STAGES-1] = !vld_s[DIV_STAGES-1] || !result_stall;
		for (int k = DIV_STAGES - 2; k >= 0; k--) begin
			free[k] = !vld_s[k] || free[k+1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (free[k] && src_v[k]) begin
				stage_s[k] <= nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (free[k]) begin
					vld_s[k] <= src_v[k];
				end
			end
		end
	end

	assign sum_stall     = !free[0];
	assign result_valid  = vld_s[DIV_STAGES-1];
	assign true_range    = stage_s[DIV_STAGES-1].tr;
	assign average_valid = stage_s[DIV_STAGES-1].avg_valid;
	// report zero until the window has filled
	assign range_average = stage_s[DIV_STAGES-1].avg_valid ?
		stage_s[DIV_STAGES-1].nq[AVG_W-1:0] : '0;

endmodule

>>> src/average_true_range.sv
// Average true range over a moving window of price bars.
// Accepted bar updates pass the queue, the ring read-modify-write, the sum
// register and the divider; the back end pops the next one only after the last one's ring update.
// The 6-stage divider and a 2-entry queue let both sides stall on their own.
// Reset (arst_n, async): history cleared, window_length 14; ring contents are
// left undefined and are only read at slots written since the last restart.
module average_true_range import atr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               bar_valid,
	output logic               bar_stall,
	input  logic [PRICE_W-1:0] bar_high,
	input  logic [PRICE_W-1:0] bar_low,
	input  logic [PRICE_W-1:0] bar_close,
	input  logic               new_bar,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [PRICE_W-1:0] true_range,
	output logic               average_valid,
	output logic [AVG_W-1:0]   range_average
);

	logic [WIN_W-1:0]     window_q;
	logic [WIN_W-1:0]     window_eff;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;
	logic                 clear;

	logic       push;
	atr_entry_t entry;
	atr_entry_t head;
	logic       full;
	logic       empty;
	logic       pop;
	logic       sum_valid;
	atr_sum_t   sum;
	logic       sum_stall;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign clear   = cfg_wr && (reg_idx == REG_WINDOW);
	assign prdata  = (reg_idx == REG_WINDOW) ? PDATA_W'(window_q) : '0;

	always_comb begin
		if (window_q == '0) begin
			window_eff = WIN_W'(1);
		end else if (window_q > WIN_W'(MAX_WINDOW)) begin
			window_eff = WIN_W'(MAX_WINDOW);
		end else begin
			window_eff = window_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (clear) begin
			window_q <= pwdata[WIN_W-1:0];
		end
	end

	atr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.window    (window_eff),
		.bar_valid (bar_valid),
		.bar_stall (bar_stall),
		.bar_high  (bar_high),
		.bar_low   (bar_low),
		.bar_close (bar_close),
		.new_bar   (new_bar),
		.full      (full),
		.push      (push),
		.entry     (entry)
	);

	atr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (entry),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	atr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.sum_valid (sum_valid),
		.sum       (sum),
		.sum_stall (sum_stall)
	);

	atr_div u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.divisor       (window_eff),
		.sum_valid     (sum_valid),
		.sum           (sum),
		.sum_stall     (sum_stall),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.true_range    (true_range),
		.average_valid (average_valid),
		.range_average (range_average)
	);

endmodule

>>> tb/atr_range_checker.sv
`timescale 1ns / 100ps
// Scoreboard for average_true_range: follows window_length writes on the APB port,
// predicts the result of every accepted bar update and checks the result stream.
// Depends on atr_pkg for widths, the register index and the window limits.
module atr_range_checker import atr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               bar_valid,
	input  logic               bar_stall,
	input  logic [PRICE_W-1:0] bar_high,
	input  logic [PRICE_W-1:0] bar_low,
	input  logic [PRICE_W-1:0] bar_close,
	input  logic               new_bar,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [PRICE_W-1:0] true_range,
	input  logic               average_valid,
	input  logic [AVG_W-1:0]   range_average,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [PRICE_W-1:0] tr;
		logic               avg_valid;
		logic [AVG_W-1:0]   avg;
	} range_result_t;

	range_result_t      expected_ranges[$];
	logic [PRICE_W-1:0] tr_ring[MAX_WINDOW];
	logic [RING_AW-1:0] slot_now;
	logic [SEEN_W-1:0]  bars_counted;
	logic [TOTAL_W-1:0] range_sum;
	logic [PRICE_W-1:0] close_before;
	logic [PRICE_W-1:0] close_now;
	logic [WIN_W-1:0]   window_len;

	task automatic clear_history();
		for (int i = 0; i < MAX_WINDOW; i++)
			tr_ring[i] = '0;
		slot_now     = '0;
		bars_counted = '0;
		range_sum    = '0;
		close_before = '0;
		close_now    = '0;
	endtask

	task automatic predict_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
			input logic [PRICE_W-1:0] cl, input logic fresh);
		logic [WIN_W-1:0]      span;
		logic                  first_bar;
		logic [PRICE_W-1:0]    upper;
		logic [PRICE_W-1:0]    lower;
		logic [DIVIDEND_W-1:0] scaled;
		range_result_t         res;
		span = window_len;
		if (span == '0) begin
			span = WIN_W'(1);
		end else if (span > WIN_W'(MAX_WINDOW)) begin
			span = WIN_W'(MAX_WINDOW);
		end
		if (bars_counted == '0) begin
			// any update after a restart opens the first bar
			slot_now     = '0;
			first_bar    = 1'b1;
			bars_counted = SEEN_W'(1);
		end else if (fresh) begin
			close_before = close_now;
			slot_now     = RING_AW'((int'(slot_now) + 1) % int'(span));
			if (bars_counted >= span)
				range_sum = range_sum - TOTAL_W'(tr_ring[slot_now]);
			if (bars_counted < SEEN_LIMIT)
				bars_counted = bars_counted + 1'b1;
			first_bar = 1'b0;
		end else begin
			// revision: replace the current bar's range
			range_sum = range_sum - TOTAL_W'(tr_ring[slot_now]);
			first_bar = (bars_counted == SEEN_W'(1));
		end
		if (first_bar) begin
			upper = hi;
			lower = lo;
		end else begin
			upper = (hi >= close_before) ? hi : close_before;
			lower = (lo <= close_before) ? lo : close_before;
		end
		res.tr            = (upper > lower) ? upper - lower : '0;
		tr_ring[slot_now] = res.tr;
		range_sum         = range_sum + TOTAL_W'(res.tr);
		close_now         = cl;
		res.avg_valid     = (bars_counted >= span);
		scaled            = {range_sum, {FRAC_BITS{1'b0}}};
		res.avg           = res.avg_valid ? AVG_W'(scaled / DIVIDEND_W'(span)) : '0;
		expected_ranges.push_back(res);
	endtask

	always @(posedge clk) begin : watch
		range_result_t want;
		if (!arst_n) begin
			clear_history();
			window_len = WINDOW_RESET;
			expected_ranges.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_WINDOW) begin
				window_len = pwdata[WIN_W-1:0];
				clear_history();
			end
			if (result_valid && !result_stall) begin
				if (expected_ranges.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result tr=%h valid=%b avg=%h", $realtime,
							true_range, average_valid, range_average);
				end else begin
					want = expected_ranges.pop_front();
					if (true_range !== want.tr || average_valid !== want.avg_valid ||
							range_average !== want.avg) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch tr %h/%h valid %b/%b avg %h/%h (expected/got)",
								$realtime, want.tr, true_range, want.avg_valid, average_valid,
								want.avg, range_average);
					end
				end
			end
			if (bar_valid && !bar_stall)
				predict_bar(bar_high, bar_low, bar_close, new_bar);
		end
		pending = expected_ranges.size();
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the average_true_range testbench: clock, reset, APB writes, bar stimulus
// and receiver stalls. Depends on atr_pkg, average_true_range and atr_range_checker.
module testbench;
	import atr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int LONG_PHASE     = 280;
	localparam int SHORT_PHASE    = 22;
	localparam int FULL_WINDOW    = 511;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               bar_valid    = 1'b0;
	logic               bar_stall;
	logic [PRICE_W-1:0] bar_high     = '0;
	logic [PRICE_W-1:0] bar_low      = '0;
	logic [PRICE_W-1:0] bar_close    = '0;
	logic               new_bar      = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [PRICE_W-1:0] true_range;
	logic               average_valid;
	logic [AVG_W-1:0]   range_average;
	int                 errors;
	int                 pending;

	int                 burst_left    = 0;
	int                 idle_cycles   = 0;
	int                 stall_left    = 0;
	logic               stall_chatter = 1'b0;
	logic [PRICE_W-1:0] level         = 32'h8000_0000;

	always #2 clk = ~clk;

	average_true_range DUT (.*);

	atr_range_checker range_check (.*);

	task automatic send_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
			input logic [PRICE_W-1:0] cl, input logic fresh);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				bar_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		bar_valid <= 1'b1;
		bar_high  <= hi;
		bar_low   <= lo;
		bar_close <= cl;
		new_bar   <= fresh;
		@(posedge clk);
		while (bar_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [PRICE_W-1:0] edge_price();
		case ($urandom_range(0, 2))
			0: edge_price = '0;
			1: edge_price = '1;
			default: edge_price = $urandom();
		endcase
	endfunction

	task automatic send_random_bar();
		logic [PRICE_W-1:0] hi;
		logic [PRICE_W-1:0] lo;
		logic [PRICE_W-1:0] cl;
		logic [PRICE_W-1:0] d_up;
		logic [PRICE_W-1:0] d_down;
		int                 kind;
		kind   = $urandom_range(0, 99);
		d_up   = $urandom_range(0, 600);
		d_down = $urandom_range(0, 600);
		// drift the price level, with a rare jump anywhere in the range
		if ($urandom_range(0, 49) == 0)
			level = $urandom();
		else
			level = level + $urandom_range(0, 2000) - 1000;
		if (kind < 70) begin
			hi = level + d_up;
			lo = level - d_down;
			cl = lo + $urandom_range(0, d_up + d_down);
		end else if (kind < 82) begin
			hi = $urandom();
			lo = $urandom();
			cl = $urandom();
		end else if (kind < 92) begin
			hi = edge_price();
			lo = edge_price();
			cl = edge_price();
		end else begin
			// low above high
			hi = level;
			lo = level + d_up + 1;
			cl = level;
		end
		send_bar(hi, lo, cl, $urandom_range(0, 3) != 0);
	endtask

	task automatic drain_results();
		bar_valid <= 1'b0;
		burst_left = 0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic write_window(input int len);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= PADDR_W'({REG_WINDOW, 2'b00});
		pwdata  <= PDATA_W'(len);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin : stimulus
		int windows[8];
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset window of 14: revision before any bar, then revision of the first bar
		send_bar(32'd100, 32'd40, 32'd70, 1'b0);
		send_bar(32'd500, 32'd10, 32'd300, 1'b0);
		send_bar('1, '0, '1, 1'b1);
		send_bar('0, '0, '0, 1'b1);
		send_bar(32'd10, 32'd20, 32'd15, 1'b1);
		send_bar('0, '0, '1, 1'b0);
		for (int i = 0; i < 12; i++)
			send_bar(32'd1000 + 7 * i, 32'd900 + 3 * i, 32'd950 + i, 1'b1);
		drain_results();
		write_window(1);
		send_bar(32'd5, 32'd9, 32'd7, 1'b1);
		send_bar('1, '0, '0, 1'b1);
		send_bar('1, '1, 32'd1, 1'b0);

		windows    = '{0, 2, FULL_WINDOW, MAX_WINDOW, 300, 0, 0, WINDOW_RESET};
		windows[5] = $urandom_range(3, 20);
		windows[6] = $urandom_range(21, 64);
		foreach (windows[p]) begin
			drain_results();
			write_window(windows[p]);
			repeat ((windows[p] == FULL_WINDOW) ? LONG_PHASE : SHORT_PHASE)
				send_random_bar();
		end
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// receiver: stall runs, free runs, long calm stretches and cycle-by-cycle chatter
	always @(negedge clk) begin : receiver_pattern
		int pick;
		pick = $urandom_range(0, 9);
		if (stall_left == 0) begin
			stall_chatter <= 1'b0;
			if (pick < 3) begin
				result_stall <= 1'b1;
				stall_left   <= $urandom_range(1, 24);
			end else if (pick < 7) begin
				result_stall <= 1'b0;
				stall_left   <= $urandom_range(1, 12);
			end else if (pick < 9) begin
				result_stall <= 1'b0;
				stall_left   <= $urandom_range(40, 120);
			end else begin
				stall_chatter <= 1'b1;
				stall_left    <= $urandom_range(8, 40);
			end
		end else begin
			stall_left <= stall_left - 1;
			if (stall_chatter)
				result_stall <= ($urandom_range(0, 1) == 1);
		end
	end

	always @(posedge clk) begin
		if ((bar_valid && !bar_stall) || (result_valid && !result_stall) ||
				(psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
